// ===== design/timed_event_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Timed event priority queue assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define TEPQ_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define TEPQ_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tepq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue package
// Field widths, codes, the stored event layout and the heap ordering rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tepq_pkg;

   localparam int TIME_W      = 63;
   localparam int KIND_W      = 3;
   localparam int CHAN_W      = 4;
   localparam int DATA_W      = 7;
   localparam int ARRIVAL_W   = 16;
   localparam int MAX_RESULTS = 32;
   localparam int N_W         = $clog2(MAX_RESULTS + 1);

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLED = 1'b0;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_DROPPED  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CONTROL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BEND     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PRESSURE = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]    deadline;
      logic [KIND_W-1:0]    kind;
      logic [CHAN_W-1:0]    chan;
      logic [DATA_W-1:0]    data_first;
      logic [DATA_W-1:0]    data_second;
      logic [ARRIVAL_W-1:0] arrival;
   } entry_type;

   // True when a must leave the heap before b: earlier deadline, and on a tie
   // the arrival number that lies behind the other in modular order.
   function automatic logic earlier(input entry_type a, input entry_type b);
      logic [ARRIVAL_W-1:0] diff;
      begin
         diff = a.arrival - b.arrival;
         earlier = (a.deadline < b.deadline) ||
                   ((a.deadline == b.deadline) && diff[ARRIVAL_W-1]);
      end
   endfunction

endpackage

// ===== design/tepq_req_if.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue request channel
// Valid/ready channel that carries enqueue and tick items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tepq_req_if;
   import tepq_pkg::*;

   logic                valid;
   logic                ready;
   logic                op;
   logic [TIME_W-1:0]   time_value;
   logic [KIND_W-1:0]   msg_kind;
   logic [CHAN_W-1:0]   chan;
   logic [DATA_W-1:0]   data_first;
   logic [DATA_W-1:0]   data_second;

   modport source (
      output valid, op, time_value, msg_kind, chan, data_first, data_second,
      input  ready
   );

   modport sink (
      input  valid, op, time_value, msg_kind, chan, data_first, data_second,
      output ready
   );
endinterface

// ===== design/tepq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue response channel
// Valid/ready channel that carries released events and drop reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tepq_rsp_if;
   import tepq_pkg::*;

   logic                valid;
   logic                ready;
   logic                status;
   logic [KIND_W-1:0]   out_kind;
   logic [CHAN_W-1:0]   out_chan;
   logic [DATA_W-1:0]   out_first;
   logic [DATA_W-1:0]   out_second;
   logic [TIME_W-1:0]   out_deadline;
   logic                last_of_run;

   modport source (
      output valid, status, out_kind, out_chan, out_first, out_second,
             out_deadline, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, status, out_kind, out_chan, out_first, out_second,
             out_deadline, last_of_run,
      output ready
   );
endinterface

// ===== design/timed_event_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue
// Holds up to CAPACITY timed events in a binary min-heap kept in one on-chip
// memory. An enqueue transfer stores an event; if the heap is full the event
// is dropped and a single response transfer with status set reports it. A
// tick transfer carries the current time and, while the enable register is
// set, releases every stored event due at or before that time, earliest
// deadline first and equal deadlines in arrival order, at most 32 per tick;
// the final response of a tick has last_of_run set. Events of an unknown kind
// are removed at their turn without a response. The block takes one item at
// a time. An enqueue moves the new event up the heap level by level
// (at most about log2(CAPACITY) levels), shifting each later parent down,
// then writes the event where it settles; a dropped enqueue passes through
// the drop state to report it, and a tick while disabled is accepted and
// ignored. An enabled tick reads and tests the heap top and, for each due
// event while events remain, walks the refill down level by level to where
// it settles; once nothing more is due it closes the tick. The heap memory
// has a single write port and registered reads, and the response side can
// stall the block. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_event_priority_queue_macros.svh"

module timed_event_priority_queue #(
   parameter int CAPACITY = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tepq_req_if.sink                        req_if,
   tepq_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tepq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tepq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tepq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tepq_pkg::*;

   // Heap index, fill count and child index widths. A child index of the
   // deepest slot can reach twice the capacity.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 2;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DROP   = 3'd1;
   localparam logic [2:0] S_UP     = 3'd2;
   localparam logic [2:0] S_PLACE  = 3'd3;
   localparam logic [2:0] S_TREAD  = 3'd4;
   localparam logic [2:0] S_TCHECK = 3'd5;
   localparam logic [2:0] S_DOWN   = 3'd6;
   localparam logic [2:0] S_FLUSH  = 3'd7;

   logic enabled;

   tepq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .enabled     (enabled)
   );

   // Sequencer state. The heap is worked with a moving "hole": the event
   // being placed sits in cur_ff while parents or children shift into the
   // hole one level per cycle, so the memory sees one write per cycle.
   logic [2:0]            state_ff,      state_in;
   logic [CNT_W-1:0]      count_ff,      count_in;
   logic [ARRIVAL_W-1:0]  arrival_ff,    arrival_in;
   logic [IDX_W-1:0]      hole_ff,       hole_in;
   entry_type             cur_ff,        cur_in;
   logic [TIME_W-1:0]     now_ff,        now_in;
   logic [N_W-1:0]        n_ff,          n_in;

   // A released event waits in the pending register until the tick knows
   // whether another one follows, which settles its last_of_run flag.
   logic                  pend_valid_ff, pend_valid_in;
   entry_type             pend_ff,       pend_in;

   // Response output register.
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic                  rsp_status_ff;
   entry_type             rsp_entry_ff;
   logic                  rsp_last_ff;

   // Heap memory: one write port, two registered read ports.
   entry_type             heap_mem_ff [CAPACITY];
   entry_type             rd_a_ff;
   entry_type             rd_b_ff;
   logic [IDX_W-1:0]      rd_a_addr;
   logic [IDX_W-1:0]      rd_b_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   logic                  req_fire;
   logic                  out_free;
   logic                  push_en;
   logic                  push_status;
   entry_type             push_entry;
   logic                  push_last;

   logic [CNT_W-1:0]      cnt_m1;
   logic [IDX_W-1:0]      new_par;
   logic [IDX_W-1:0]      hole_par;
   logic [IDX_W-1:0]      hole_par_par;
   logic [CH_W-1:0]       hole_l;
   logic [CH_W-1:0]       hole_r;
   logic                  l_ok;
   logic                  r_ok;
   logic                  take_l;
   logic                  take_r;
   logic                  due;
   logic                  known_kind;
   logic                  base_sel;
   logic [IDX_W-1:0]      base_idx;
   logic [CH_W-1:0]       base_l;
   logic [CH_W-1:0]       base_r;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign cnt_m1       = count_ff - CNT_W'(1);
   assign new_par      = (count_ff[IDX_W-1:0] - IDX_W'(1)) >> 1;
   assign hole_par     = (hole_ff - IDX_W'(1)) >> 1;
   assign hole_par_par = (hole_par - IDX_W'(1)) >> 1;
   assign hole_l       = (CH_W'(hole_ff) << 1) + CH_W'(1);
   assign hole_r       = hole_l + CH_W'(1);
   assign l_ok         = hole_l < CH_W'(count_ff);
   assign r_ok         = hole_r < CH_W'(count_ff);

   // Sift-down choice, made exactly as a left-then-right scan: the right
   // child is tested against whichever of the hole event or left child won.
   assign take_l = l_ok && earlier(rd_a_ff, cur_ff);
   assign take_r = r_ok && (take_l ? earlier(rd_b_ff, rd_a_ff) : earlier(rd_b_ff, cur_ff));

   // The top event is due when one is stored, its deadline has come, and
   // the tick has not yet released its maximum number of events.
   assign due = (count_ff != '0) && (rd_a_ff.deadline <= now_ff) &&
                (n_ff != N_W'(MAX_RESULTS));

   always_comb begin
      known_kind = rd_a_ff.kind inside {[KIND_NOTE_ON:KIND_PRESSURE]};
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      arrival_in    = arrival_ff;
      hole_in       = hole_ff;
      cur_in        = cur_ff;
      now_in        = now_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      wr_en         = 1'b0;
      wr_addr       = hole_ff;
      wr_data       = cur_ff;
      rd_a_addr     = '0;
      rd_b_addr     = cnt_m1[IDX_W-1:0];
      push_en       = 1'b0;
      push_status   = STATUS_RELEASED;
      push_entry    = pend_ff;
      push_last     = 1'b0;
      base_sel      = 1'b0;
      base_idx      = '0;
      base_l        = '0;
      base_r        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_if.op == OP_ENQUEUE) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     state_in = S_DROP;
                  end else begin
                     cur_in.deadline    = req_if.time_value;
                     cur_in.kind        = req_if.msg_kind;
                     cur_in.chan        = req_if.chan;
                     cur_in.data_first  = req_if.data_first;
                     cur_in.data_second = req_if.data_second;
                     cur_in.arrival     = arrival_ff;
                     arrival_in         = arrival_ff + ARRIVAL_W'(1);
                     count_in           = count_ff + CNT_W'(1);
                     hole_in            = count_ff[IDX_W-1:0];
                     if (count_ff == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        rd_a_addr = new_par;
                        state_in  = S_UP;
                     end
                  end
               end else if (enabled) begin
                  now_in   = req_if.time_value;
                  n_in     = '0;
                  state_in = S_TREAD;
               end
            end
         end

         S_DROP: begin
            if (out_free) begin
               push_en     = 1'b1;
               push_status = STATUS_DROPPED;
               push_entry  = '0;
               push_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end

         // Parent of the hole arrived last cycle; shift it down or settle.
         S_UP: begin
            wr_en = 1'b1;
            if (earlier(cur_ff, rd_a_ff)) begin
               wr_data = rd_a_ff;
               hole_in = hole_par;
               if (hole_par == '0) begin
                  state_in = S_PLACE;
               end else begin
                  rd_a_addr = hole_par_par;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            state_in = S_IDLE;
         end

         // Fetch the heap top and the last stored event together.
         S_TREAD: begin
            state_in = S_TCHECK;
         end

         S_TCHECK: begin
            if (!due) begin
               state_in = S_FLUSH;
            end else if (!(known_kind && pend_valid_ff && !out_free)) begin
               if (known_kind) begin
                  if (pend_valid_ff) begin
                     push_en = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = rd_a_ff;
                  n_in          = n_ff + N_W'(1);
               end
               count_in = cnt_m1;
               if (cnt_m1 == '0) begin
                  state_in = S_TREAD;
               end else begin
                  // The last event refills the root and walks down.
                  cur_in   = rd_b_ff;
                  hole_in  = '0;
                  base_sel = 1'b1;
                  state_in = S_DOWN;
               end
            end
         end

         S_DOWN: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data  = rd_b_ff;
               hole_in  = hole_r[IDX_W-1:0];
               base_sel = 1'b1;
               base_idx = hole_r[IDX_W-1:0];
            end else if (take_l) begin
               wr_data  = rd_a_ff;
               hole_in  = hole_l[IDX_W-1:0];
               base_sel = 1'b1;
               base_idx = hole_l[IDX_W-1:0];
            end else begin
               state_in = S_TREAD;
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push_en       = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Read both children of the new hole position for the next level.
      // Children outside the heap read slot zero and are ignored.
      if (base_sel) begin
         base_l    = (CH_W'(base_idx) << 1) + CH_W'(1);
         base_r    = base_l + CH_W'(1);
         rd_a_addr = (base_l < CH_W'(count_in)) ? base_l[IDX_W-1:0] : '0;
         rd_b_addr = (base_r < CH_W'(count_in)) ? base_r[IDX_W-1:0] : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem_ff[rd_a_addr];
      rd_b_ff <= heap_mem_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         arrival_ff    <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         arrival_ff    <= arrival_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      cur_ff  <= cur_in;
      now_ff  <= now_in;
      pend_ff <= pend_in;
      if (push_en) begin
         rsp_status_ff <= push_status;
         rsp_entry_ff  <= push_entry;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.out_kind     = rsp_entry_ff.kind;
   assign rsp_if.out_chan     = rsp_entry_ff.chan;
   assign rsp_if.out_first    = rsp_entry_ff.data_first;
   assign rsp_if.out_second   = rsp_entry_ff.data_second;
   assign rsp_if.out_deadline = rsp_entry_ff.deadline;
   assign rsp_if.last_of_run  = rsp_last_ff;

   // The fill count never passes the capacity.
   `TEPQ_CHECK(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "heap count above capacity")

   // Every heap write lands inside the occupied part of the heap.
   `TEPQ_CHECK(a_write_in_heap, wr_en, CNT_W'(wr_addr) < count_ff, "heap write outside heap")

   // A drop report always closes its run.
   `TEPQ_CHECK(a_drop_is_last, rsp_valid_ff && (rsp_status_ff == STATUS_DROPPED),
      rsp_last_ff, "drop report without last flag")

   // No released event is left behind once the block is idle again.
   `TEPQ_CHECK(a_no_stale_pending, state_ff == S_IDLE, !pend_valid_ff,
      "pending event left at idle")

   // An enqueue that fits grows the heap by exactly one.
   `TEPQ_NEXT(a_enqueue_grows, req_fire && (req_if.op == OP_ENQUEUE) &&
      (count_ff != CNT_W'(CAPACITY)),
      count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "enqueue did not grow heap")
endmodule

// ===== design/tepq_csr.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue register block
// APB-style access to the enable register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tepq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tepq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tepq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tepq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic                            enabled
);
   import tepq_pkg::*;

   logic                   enabled_ff;
   logic                   enabled_in;
   logic                   wr_fire;
   logic [CSR_INDEX_W-1:0] reg_index;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign enabled    = enabled_ff;

   always_comb begin
      enabled_in = enabled_ff;
      if (wr_fire && (reg_index == REG_ENABLED)) begin
         enabled_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_ENABLED) begin
         csr_prdata = CSR_DATA_W'(enabled_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else begin
         enabled_ff <= enabled_in;
      end
   end
endmodule
